>>> hdl/soad_pkg.sv
// Package for the sonar obstacle-avoid decision core: store geometry,
// transaction structs, register indexes, scan sequencer states and helpers.
// No dependencies.
package soad_pkg;

    // Range store geometry
    localparam int NUM_SONARS = 32;
    localparam int IDX_W      = (NUM_SONARS > 1) ? $clog2(NUM_SONARS) : 1;
    localparam int RANGE_W    = 16;
    localparam int VEL_W      = 16;
    localparam int BOUND_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_BOUND     = 3'd0,
        CFG_RIGHT_BOUND    = 3'd1,
        CFG_AVOID_DISTANCE = 3'd2,
        CFG_HALT_DISTANCE  = 3'd3,
        CFG_DRIVE_SPEED    = 3'd4,
        CFG_TURN_RATE      = 3'd5
    } t_cfg_idx;

    // Input transaction
    typedef struct packed {
        logic [BOUND_W-1:0]      sensor_index;
        logic [RANGE_W-1:0]      range_value;
        logic                    bunch_end;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic                    avoid_active;
        logic signed [VEL_W-1:0] translation_out;
        logic signed [VEL_W-1:0] rotation_out;
    } t_out_item;

    // Scan request from the top level to the sequencer
    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } t_scan_req;

    // Scan status and result back to the top level
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [RANGE_W-1:0] minimum;
        logic [IDX_W-1:0]   id;
    } t_scan_res;

    // Scan sequencer states
    typedef enum logic [1:0] {
        SC_IDLE,
        SC_RUN,
        SC_DONE
    } t_scan_state;

    // Saturate a bound to the last sonar of the store
    function automatic logic [IDX_W-1:0] clamp_bound(input logic [BOUND_W-1:0] b);
        logic [IDX_W-1:0] r;
        if (int'(b) >= NUM_SONARS) begin
            r = IDX_W'(NUM_SONARS - 1);
        end else begin
            r = IDX_W'(b);
        end
        return r;
    endfunction

endpackage

>>> hdl/sonar_obstacle_avoid_decision_core.sv
// Top level of the sonar obstacle-avoid decision core: configuration
// registers, range store with valid bits, decision and output register.
// Depends on soad_pkg, soad_ram and soad_scan.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | i_in_valid, o_in_stall, i_in (t_in_item)  | into core
//  out      | o_out_valid, i_out_stall, o_out           | out of core
//  cfg      | i_cfg_valid, o_cfg_ready, i_cfg_index,    | into core
//           | i_cfg_data                                |
//
// Readings without bunch_end are taken back to back, with no stall.
// A bunch_end reading holds the input stalled while the scan walks lo to hi
// through the single store read port, and until its result is taken.
// Output register loads the result once the scan is done and the slot frees.
// Reset is synchronous; valid bits clear the range store at once.
// A stalled result holds the scan in its done state until the slot frees.
module sonar_obstacle_avoid_decision_core
    import soad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [BOUND_W-1:0]      r_left_bound;
    logic [BOUND_W-1:0]      r_right_bound;
    logic [RANGE_W-1:0]      r_avoid_dist;
    logic [RANGE_W-1:0]      r_halt_dist;
    logic signed [VEL_W-1:0] r_drive_speed;
    logic signed [VEL_W-1:0] r_turn_rate;

    logic [NUM_SONARS-1:0]   r_valid;
    logic                    r_rd_ok;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out,       n_out;

    logic                    in_accept;
    logic                    store_we;
    logic [IDX_W-1:0]        store_waddr;
    logic [IDX_W-1:0]        rd_addr;
    logic [RANGE_W-1:0]      ram_q;
    logic [RANGE_W-1:0]      rd_data;
    t_scan_req               scan_req;
    t_scan_res               scan_res;
    logic                    out_load;

    logic [IDX_W-1:0]        lb, rb;
    logic [IDX_W-1:0]        dl, dr;
    logic signed [VEL_W-1:0] neg_turn;

    // Accept readings only while the scan is idle
    assign o_in_stall  = scan_res.busy;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bound  <= '0;
            r_right_bound <= BOUND_W'(31);
            r_avoid_dist  <= '0;
            r_halt_dist   <= '0;
            r_drive_speed <= '0;
            r_turn_rate   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LEFT_BOUND:     r_left_bound  <= i_cfg_data[BOUND_W-1:0];
                CFG_RIGHT_BOUND:    r_right_bound <= i_cfg_data[BOUND_W-1:0];
                CFG_AVOID_DISTANCE: r_avoid_dist  <= i_cfg_data;
                CFG_HALT_DISTANCE:  r_halt_dist   <= i_cfg_data;
                CFG_DRIVE_SPEED:    r_drive_speed <= i_cfg_data;
                CFG_TURN_RATE:      r_turn_rate   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Store the reading if its sensor lies inside the store
    assign store_we    = in_accept && (int'(i_in.sensor_index) < NUM_SONARS);
    assign store_waddr = IDX_W'(i_in.sensor_index);

    soad_ram #(
        .WIDTH (RANGE_W),
        .DEPTH (NUM_SONARS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (i_in.range_value),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (store_we) begin
            r_valid[store_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= r_valid[rd_addr];
    end

    assign rd_data = r_rd_ok ? ram_q : '0;

    // Scan window from the saturated bounds
    assign lb          = clamp_bound(r_left_bound);
    assign rb          = clamp_bound(r_right_bound);
    assign scan_req.start = in_accept && i_in.bunch_end;
    assign scan_req.lo    = (lb < rb) ? lb : rb;
    assign scan_req.hi    = (lb < rb) ? rb : lb;

    soad_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (scan_req),
        .i_ack     (out_load),
        .i_rd_data (rd_data),
        .o_rd_addr (rd_addr),
        .o_res     (scan_res)
    );

    // Decide on the found minimum
    assign dl       = (lb >= scan_res.id) ? (lb - scan_res.id) : (scan_res.id - lb);
    assign dr       = (rb >= scan_res.id) ? (rb - scan_res.id) : (scan_res.id - rb);
    assign neg_turn = (r_turn_rate == {1'b1, {(VEL_W-1){1'b0}}}) ?
                      {1'b0, {(VEL_W-1){1'b1}}} : -r_turn_rate;

    always_comb begin
        n_out = r_out;
        if (out_load) begin
            if (scan_res.minimum < r_avoid_dist) begin
                n_out.avoid_active    = 1'b1;
                n_out.translation_out = (scan_res.minimum < r_halt_dist) ?
                                        '0 : r_drive_speed;
                n_out.rotation_out    = (dl > dr) ? r_turn_rate : neg_turn;
            end else begin
                n_out.avoid_active    = 1'b0;
                n_out.translation_out = '0;
                n_out.rotation_out    = '0;
            end
        end
    end

    // Output register: load when the slot is free or being emptied
    assign out_load    = scan_res.done && (!r_out_valid || !i_out_stall);
    assign n_out_valid = out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A bunch end starts a scan and stalls the input
    a_bunch_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in.bunch_end) |=> o_in_stall)
        else $error("bunch end did not start a scan");

    // A fresh result only follows a finished scan
    a_out_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(scan_res.done))
        else $error("result appeared without a finished scan");

    // An inactive result carries zero velocities
    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.avoid_active) |->
            (o_out.translation_out == '0) && (o_out.rotation_out == '0))
        else $error("inactive result with non-zero velocity");

endmodule

>>> hdl/soad_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module soad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/soad_scan.sv
// Minimum-search sequencer: walks the range store from lo to hi through one
// shared comparator, one entry a cycle. Depends on soad_pkg.
module soad_scan
    import soad_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_scan_req          i_req,
    input  logic               i_ack,
    input  logic [RANGE_W-1:0] i_rd_data,
    output logic [IDX_W-1:0]   o_rd_addr,
    output t_scan_res          o_res
);

    t_scan_state        r_state,      n_state;
    logic [IDX_W-1:0]   r_addr,       n_addr;
    logic [IDX_W-1:0]   r_hi,         n_hi;
    logic               r_pend,       n_pend;
    logic [IDX_W-1:0]   r_pidx,       n_pidx;
    logic               r_issue_done, n_issue_done;
    logic               r_first,      n_first;
    logic [RANGE_W-1:0] r_min,        n_min;
    logic [IDX_W-1:0]   r_id,         n_id;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= SC_IDLE;
            r_pend       <= 1'b0;
            r_issue_done <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend       <= n_pend;
            r_issue_done <= n_issue_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_hi    <= n_hi;
        r_pidx  <= n_pidx;
        r_first <= n_first;
        r_min   <= n_min;
        r_id    <= n_id;
    end

    // Sequence address issue and compare
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_hi         = r_hi;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_issue_done = r_issue_done;
        n_first      = r_first;
        n_min        = r_min;
        n_id         = r_id;
        case (r_state)
            SC_IDLE: begin
                n_pend = 1'b0;
                if (i_req.start) begin
                    n_addr       = i_req.lo;
                    n_hi         = i_req.hi;
                    n_issue_done = 1'b0;
                    n_first      = 1'b1;
                    n_state      = SC_RUN;
                end
            end
            SC_RUN: begin
                // issue the next read
                if (!r_issue_done) begin
                    n_pend = 1'b1;
                    n_pidx = r_addr;
                    if (r_addr == r_hi) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end else begin
                    n_pend = 1'b0;
                end
                // compare the entry that has come back; first strict minimum wins
                if (r_pend) begin
                    if (r_first || (i_rd_data < r_min)) begin
                        n_min = i_rd_data;
                        n_id  = r_pidx;
                    end
                    n_first = 1'b0;
                    if (r_pidx == r_hi) begin
                        n_pend  = 1'b0;
                        n_state = SC_DONE;
                    end
                end
            end
            SC_DONE: begin
                if (i_ack) begin
                    n_state = SC_IDLE;
                end
            end
            default: begin
                n_state = SC_IDLE;
            end
        endcase
    end

    assign o_rd_addr     = r_addr;
    assign o_res.busy    = (r_state != SC_IDLE);
    assign o_res.done    = (r_state == SC_DONE);
    assign o_res.minimum = r_min;
    assign o_res.id      = r_id;

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sonar_obstacle_avoid_decision_core: a queued reading driver,
// a result monitor checked against an in-bench steering predictor, phased register settings.
// Depends on soad_pkg and the core RTL.
module tb;
    import soad_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = NUM_SONARS + 8;
    localparam int MAX_PRINTED    = 50;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_READINGS = 144;

    // Register indexes outside the map; writes to them must leave the settings alone
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        t_in_item rd;
        bit       drain_first;
    } t_queued_reading;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Pending readings and the steering commands they are expected to produce
    t_queued_reading reading_q[$];
    t_out_item       steer_q[$];

    // Bench copy of the range store and the register settings
    logic [RANGE_W-1:0]      ranges [NUM_SONARS] = '{default: '0};
    logic [BOUND_W-1:0]      win_left  = 5'd0;
    logic [BOUND_W-1:0]      win_right = 5'd31;
    logic [RANGE_W-1:0]      avoid_lim = '0;
    logic [RANGE_W-1:0]      halt_lim  = '0;
    logic signed [VEL_W-1:0] drive_cmd = '0;
    logic signed [VEL_W-1:0] turn_cmd  = '0;

    int idle_pct       = 0;
    int stall_pct      = 0;
    int mismatches     = 0;
    int readings_sent  = 0;
    int decisions_seen = 0;
    int settings_used  = 0;
    int quiet_cycles   = 0;

    sonar_obstacle_avoid_decision_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Store a reading and, at the end of a bunch, predict the steering command
    function automatic void apply_reading(input t_in_item rd);
        int                 lb, rb, lo, hi, k, best_id, dl, dr, rot;
        logic [RANGE_W-1:0] best;
        t_out_item          res;
        if (int'(rd.sensor_index) < NUM_SONARS) begin
            ranges[rd.sensor_index] = rd.range_value;
        end
        if (!rd.bunch_end) begin
            return;
        end
        lb = (int'(win_left) >= NUM_SONARS) ? NUM_SONARS - 1 : int'(win_left);
        rb = (int'(win_right) >= NUM_SONARS) ? NUM_SONARS - 1 : int'(win_right);
        lo = (lb < rb) ? lb : rb;
        hi = (lb < rb) ? rb : lb;
        // First strict minimum across the window
        best    = ranges[lo];
        best_id = lo;
        for (k = lo + 1; k <= hi; k++) begin
            if (ranges[k] < best) begin
                best    = ranges[k];
                best_id = k;
            end
        end
        res = '0;
        if (best < avoid_lim) begin
            res.avoid_active    = 1'b1;
            res.translation_out = (best < halt_lim) ? '0 : drive_cmd;
            dl = lb - best_id;
            dr = rb - best_id;
            if (dl < 0) dl = -dl;
            if (dr < 0) dr = -dr;
            // Turn away from the nearer bound; a tie turns negative, saturating
            rot = turn_cmd;
            if (dl <= dr) begin
                rot = -rot;
                if (rot > 32767) rot = 32767;
            end
            res.rotation_out = rot[VEL_W-1:0];
        end
        steer_q.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch on result %0d: %s got %0d want %0d",
                     decisions_seen, what, got, want);
        end
    endtask

    // Write one register through the configuration channel and track it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LEFT_BOUND:     win_left  = val[BOUND_W-1:0];
            CFG_RIGHT_BOUND:    win_right = val[BOUND_W-1:0];
            CFG_AVOID_DISTANCE: avoid_lim = val[RANGE_W-1:0];
            CFG_HALT_DISTANCE:  halt_lim  = val[RANGE_W-1:0];
            CFG_DRIVE_SPEED:    drive_cmd = val[VEL_W-1:0];
            CFG_TURN_RATE:      turn_cmd  = val[VEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [BOUND_W-1:0] l, input logic [BOUND_W-1:0] r,
                             input logic [15:0] avoid, input logic [15:0] halt,
                             input logic [15:0] speed, input logic [15:0] turn);
        write_reg(CFG_LEFT_BOUND, CFG_DATA_W'(l));
        write_reg(CFG_RIGHT_BOUND, CFG_DATA_W'(r));
        write_reg(CFG_AVOID_DISTANCE, avoid);
        write_reg(CFG_HALT_DISTANCE, halt);
        write_reg(CFG_DRIVE_SPEED, speed);
        write_reg(CFG_TURN_RATE, turn);
        settings_used++;
    endtask

    // Hold until every reading is in and every result out, then let the scan finish
    task automatic settle();
        do @(negedge clk); while (reading_q.size() != 0 || in_valid || steer_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic queue_reading(input int idx, input logic [RANGE_W-1:0] rng,
                                 input bit last, input bit drain);
        t_queued_reading q;
        q.rd.sensor_index = BOUND_W'(idx);
        q.rd.range_value  = rng;
        q.rd.bunch_end    = last;
        q.drain_first     = drain;
        reading_q.push_back(q);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [BOUND_W-1:0] pick_bound();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return BOUND_W'($urandom_range(NUM_SONARS - 1));
        endcase
    endfunction

    // Ranges clustered on the thresholds so that both sides of each compare are hit
    function automatic logic [RANGE_W-1:0] pick_range();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30) return avoid_lim + RANGE_W'($urandom_range(4)) - RANGE_W'(2);
        if (sel < 50) return halt_lim + RANGE_W'($urandom_range(4)) - RANGE_W'(2);
        if (sel < 55) return '0;
        if (sel < 60) return '1;
        return RANGE_W'($urandom);
    endfunction

    // One random phase: new settings, an idle and stall mix, mostly whole bunches over the window
    task automatic run_phase(input int p);
        int sel, n, len, start, width, lo, hi, j;
        case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 49; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 49; end
            default: begin idle_pct = 32; stall_pct = 32; end
        endcase
        case (p)
            1:       configure(5'd31, 5'd0, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000);
            4:       configure(5'd0, 5'd0, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
            default: configure(pick_bound(), pick_bound(), pick_word(), pick_word(),
                               pick_word(), pick_word());
        endcase
        lo    = (win_left < win_right) ? int'(win_left) : int'(win_right);
        hi    = (win_left < win_right) ? int'(win_right) : int'(win_left);
        width = hi - lo + 1;
        n     = 0;
        while (n < PHASE_READINGS) begin
            sel = $urandom_range(99);
            if (sel < 75) begin
                // Well-formed bunch walking the window
                len   = $urandom_range(8, 1);
                start = $urandom_range(width - 1);
                for (j = 0; j < len; j++) begin
                    queue_reading(lo + (start + j) % width, pick_range(), j == len - 1,
                                  n == PHASE_READINGS / 2);
                    n++;
                end
            end else if (sel < 90) begin
                // Single reading anywhere, end flag at random
                queue_reading($urandom_range(NUM_SONARS - 1), RANGE_W'($urandom),
                              1'($urandom_range(1)), n == PHASE_READINGS / 2);
                n++;
            end else begin
                // Broken bunch that never ends
                len = $urandom_range(4, 1);
                for (j = 0; j < len; j++) begin
                    queue_reading($urandom_range(NUM_SONARS - 1), pick_range(), 1'b0,
                                  n == PHASE_READINGS / 2);
                    n++;
                end
            end
        end
        settle();
    endtask

    // Reading driver: predict on each accepted transaction, then present the next
    always @(posedge clk) begin : reading_driver
        t_queued_reading nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                apply_reading(in_item);
                readings_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (reading_q.size() != 0
                        && !(reading_q[0].drain_first && steer_q.size() != 0)
                        && $urandom_range(99) >= idle_pct) begin
                    nxt = reading_q.pop_front();
                    in_valid <= 1'b1;
                    in_item  <= nxt.rd;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted transaction with the oldest prediction
    always @(posedge clk) begin : steer_monitor
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (steer_q.size() == 0) begin
                    report_mismatch("unexpected result, active", out_item.avoid_active, 0);
                end else begin
                    want = steer_q.pop_front();
                    if (out_item.avoid_active !== want.avoid_active)
                        report_mismatch("avoid_active", out_item.avoid_active,
                                        want.avoid_active);
                    if (out_item.translation_out !== want.translation_out)
                        report_mismatch("translation_out", out_item.translation_out,
                                        want.translation_out);
                    if (out_item.rotation_out !== want.rotation_out)
                        report_mismatch("rotation_out", out_item.rotation_out,
                                        want.rotation_out);
                end
                decisions_seen++;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                    || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, steer_q.size());
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : sequence_ctl
        int p;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings over a cleared store: full window, minimum zero, never active
        queue_reading(31, 16'hFFFF, 1'b0, 1'b0);
        queue_reading(0, 16'h0000, 1'b1, 1'b0);
        settle();

        // Reversed bounds, most negative turn rate
        configure(5'd8, 5'd4, 16'd2000, 16'd1000, 16'h7FFF, 16'h8000);
        queue_reading(4, 16'hFFFF, 1'b0, 1'b0);
        queue_reading(5, 16'hFFFF, 1'b0, 1'b0);
        queue_reading(6, 16'hFFFF, 1'b0, 1'b0);
        queue_reading(7, 16'hFFFF, 1'b0, 1'b0);
        queue_reading(8, 16'd1500, 1'b1, 1'b0);  // nearer the left bound
        queue_reading(6, 16'd1500, 1'b1, 1'b0);  // tie: first wins, equidistant
        queue_reading(5, 16'd999, 1'b1, 1'b0);   // below halt: no translation
        queue_reading(5, 16'hFFFF, 1'b0, 1'b0);
        queue_reading(6, 16'hFFFF, 1'b0, 1'b0);
        queue_reading(8, 16'd2000, 1'b1, 1'b0);  // exactly at avoid: inactive
        queue_reading(31, 16'h0000, 1'b1, 1'b0); // outside the window
        settle();

        // Single-sensor window at the top index, extreme speeds
        configure(5'd31, 5'd31, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF);
        queue_reading(31, 16'h0000, 1'b1, 1'b0);
        queue_reading(31, 16'hFFFF, 1'b1, 1'b0);
        queue_reading(31, 16'hFFFE, 1'b1, 1'b0);
        settle();

        // Writes to unmapped indexes must change nothing
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h1234);
        queue_reading(31, 16'hFFFE, 1'b1, 1'b0);
        settle();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            run_phase(p);
        end

        $display("summary: %0d readings driven, %0d steering results checked",
                 readings_sent, decisions_seen);
        $display("summary: %0d register settings under four idle and stall mixes",
                 settings_used);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
